// ----- sv/pfe_pkg.sv -----
// shared types, constants and saturation helpers for the postfix evaluator
package pfe_pkg;

  localparam int VAL_W             = 48;
  localparam int STACK_DEPTH_DEF   = 64;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_CHAR  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_OVERFLOW  = 3'd3,
    STAT_DIV_ZERO  = 3'd4,
    STAT_LEFTOVER  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WB
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  function automatic val_t abs_val(input val_t v);
    return v[VAL_W-1] ? (~v + val_t'(1)) : v;
  endfunction

  // big: magnitude reached 2^47 or more
  function automatic val_t sat_mag(input logic big, input logic [VAL_W-2:0] mag,
                                   input logic neg);
    if (neg) begin
      return big ? VAL_MIN : (~{1'b0, mag} + val_t'(1));
    end
    return big ? VAL_MAX : {1'b0, mag};
  endfunction

endpackage

// ----- sv/postfix_expression_evaluator_core.sv -----
// top level of the postfix expression evaluator
//
// in_* channel: one expression character per item in in_tdata, in_tlast on
// the final character of an expression. out_* channel: one result item per
// character with the stack top (signed fixed point, FRACTION_BITS fraction
// bits), the latched status, and out_tlast on the result that closes the
// expression; after it the stack and status are cleared.
// a four-entry command queue decouples intake from execution, so characters
// keep flowing in while a result waits on a stalled receiver; in_tready drops
// once the queue is full.
// execution side: digits, bad characters, characters that raise an error and
// characters skipped after an error finish in the idle state; add and subtract
// pass through the write-back state (stack refill read from the stack memory);
// multiply (four 24x24 partial products) and divide (one quotient bit a cycle)
// run their unit before write-back. a stack memory of STACK_DEPTH words holds
// the values. reset (rst_n low, synchronous) empties the queue, the stack and
// the status; no clearing pass is needed.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH   = pfe_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = pfe_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [47:0] top_value, [50:48] status, rest zero
  output logic        out_tlast
);

  logic             cmd_valid;
  pfe_pkg::cmd_t    cmd;
  logic             cmd_pop;
  pfe_pkg::val_t    top;
  pfe_pkg::status_t status;

  pfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pfe_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_top    (top),
    .out_status (status),
    .out_done   (out_tlast)
  );

  assign out_tdata = {5'b0, status, top};

endmodule

// ----- sv/pfe_front.sv -----
// input side: symbol classification and command queue
module pfe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          cmd_valid,
  output pfe_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int QD  = pfe_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_STAR  = 8'h2a;
  localparam logic [7:0] CHR_SLASH = 8'h2f;

  pfe_pkg::cmd_t  queue_r [QD];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           push;
  pfe_pkg::cmd_t  cls;

  always_comb begin
    cls.last  = in_tlast;
    cls.digit = 4'(in_tdata - CHR_ZERO);
    priority if (in_tdata >= CHR_ZERO && in_tdata <= CHR_NINE) begin
      cls.op = pfe_pkg::OP_DIGIT;
    end else if (in_tdata == CHR_PLUS) begin
      cls.op = pfe_pkg::OP_ADD;
    end else if (in_tdata == CHR_MINUS) begin
      cls.op = pfe_pkg::OP_SUB;
    end else if (in_tdata == CHR_STAR) begin
      cls.op = pfe_pkg::OP_MUL;
    end else if (in_tdata == CHR_SLASH) begin
      cls.op = pfe_pkg::OP_DIV;
    end else begin
      cls.op = pfe_pkg::OP_BAD;
    end
  end

  assign in_tready = (count_r != (QAW+1)'(QD));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/pfe_mul.sv -----
// fixed point multiplier built from four 24 by 24 partial products
module pfe_mul #(
  parameter int FRACTION_BITS = pfe_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  pfe_pkg::val_t a,
  input  pfe_pkg::val_t b,
  output logic          done,
  output pfe_pkg::val_t res
);

  localparam int VW = pfe_pkg::VAL_W;
  localparam int HW = VW / 2;
  localparam int PW = 2 * VW;

  logic          busy_r, busy_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          done_r, done_nxt;
  pfe_pkg::val_t ma_r, mb_r;
  logic          neg_r;
  logic [VW-1:0] pp_r;
  logic [1:0]    pp_sh_r;
  logic [PW-1:0] acc_r;
  pfe_pkg::val_t res_r;
  logic [HW-1:0] a_half, b_half;
  logic [PW-1:0] pp_ext;
  logic [PW-1:0] prod_sh;

  assign a_half  = step_r[0] ? ma_r[VW-1:HW] : ma_r[HW-1:0];
  assign b_half  = step_r[1] ? mb_r[VW-1:HW] : mb_r[HW-1:0];
  assign prod_sh = acc_r >> FRACTION_BITS;

  always_comb begin
    unique case (pp_sh_r)
      2'd0:    pp_ext = {{VW{1'b0}}, pp_r};
      2'd1:    pp_ext = {{HW{1'b0}}, pp_r, {HW{1'b0}}};
      2'd2:    pp_ext = {pp_r, {VW{1'b0}}};
      default: pp_ext = '0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd5) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= pfe_pkg::abs_val(a);
      mb_r  <= pfe_pkg::abs_val(b);
      neg_r <= a[VW-1] ^ b[VW-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r <= 3'd3) begin
        pp_r    <= VW'(a_half) * VW'(b_half);
        pp_sh_r <= 2'(step_r[0]) + 2'(step_r[1]);
      end
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        acc_r <= acc_r + pp_ext;
      end
      if (step_r == 3'd5) begin
        res_r <= pfe_pkg::sat_mag(|prod_sh[PW-1:VW-1], prod_sh[VW-2:0], neg_r);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ----- sv/pfe_div.sv -----
// fixed point divider, restoring, one quotient bit per cycle
module pfe_div #(
  parameter int FRACTION_BITS = pfe_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  pfe_pkg::val_t a,
  input  pfe_pkg::val_t b,
  output logic          done,
  output pfe_pkg::val_t res
);

  localparam int VW = pfe_pkg::VAL_W;
  localparam int QW = VW + FRACTION_BITS;
  localparam int SW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          done_r, done_nxt;
  logic [QW-1:0] q_r;
  logic [VW-1:0] rem_r;
  pfe_pkg::val_t mb_r;
  logic          neg_r;
  pfe_pkg::val_t res_r;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign rem_sub = rem_sh - {1'b0, mb_r};
  assign ge      = (rem_sh >= {1'b0, mb_r});

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(QW);
    end else if (busy_r) begin
      if (step_r != '0) begin
        step_nxt = step_r - SW'(1);
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= QW'(pfe_pkg::abs_val(a)) << FRACTION_BITS;
      rem_r <= '0;
      mb_r  <= pfe_pkg::abs_val(b);
      neg_r <= a[VW-1] ^ b[VW-1];
    end else if (busy_r) begin
      if (step_r != '0) begin
        rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        q_r   <= {q_r[QW-2:0], ge};
      end else begin
        res_r <= pfe_pkg::sat_mag(|q_r[QW-1:VW-1], q_r[VW-2:0], neg_r);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ----- sv/pfe_back.sv -----
// execution side: value stack, operation sequencer and result register
module pfe_back #(
  parameter int STACK_DEPTH   = pfe_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = pfe_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  pfe_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pfe_pkg::val_t    out_top,
  output pfe_pkg::status_t out_status,
  output logic             out_done
);

  localparam int VW = pfe_pkg::VAL_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  pfe_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  pfe_pkg::status_t err_r, err_nxt;
  pfe_pkg::val_t    tos_r, tos_nxt;
  pfe_pkg::val_t    nos_r, nos_nxt;
  pfe_pkg::val_t    res_r, res_nxt;
  logic             last_r, last_nxt;

  logic             out_valid_r, out_valid_nxt;
  pfe_pkg::val_t    out_top_r, out_top_nxt;
  pfe_pkg::status_t out_status_r, out_status_nxt;
  logic             out_done_r, out_done_nxt;

  pfe_pkg::val_t    mem [STACK_DEPTH];
  pfe_pkg::val_t    rd_data_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  pfe_pkg::val_t    mem_wdata;

  logic             out_free, start_ok;
  logic [CW-1:0]    cnt_m2, cnt_m3;
  pfe_pkg::val_t    digit_val;
  pfe_pkg::val_t    addsub_res;
  logic             mul_start, mul_done, div_start, div_done;
  pfe_pkg::val_t    mul_res, div_res;

  function automatic pfe_pkg::val_t sat_addsub(input pfe_pkg::val_t l,
                                               input pfe_pkg::val_t r,
                                               input logic sub);
    logic [VW:0] s;
    s = sub ? ({l[VW-1], l} - {r[VW-1], r}) : ({l[VW-1], l} + {r[VW-1], r});
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? pfe_pkg::VAL_MIN : pfe_pkg::VAL_MAX;
    end
    return s[VW-1:0];
  endfunction

  assign out_free   = !out_valid_r || out_ready;
  assign start_ok   = cmd_valid && out_free && (state_r == pfe_pkg::S_IDLE);
  assign cmd_pop    = start_ok;
  assign cnt_m2     = cnt_r - CW'(2);
  assign cnt_m3     = cnt_r - CW'(3);
  assign digit_val  = pfe_pkg::val_t'(cmd.digit) << FRACTION_BITS;
  assign addsub_res = sat_addsub(nos_r, tos_r, cmd.op == pfe_pkg::OP_SUB);

  pfe_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (nos_r),
    .b     (tos_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  pfe_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (nos_r),
    .b     (tos_r),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfe_pkg::S_IDLE: begin
        if (start_ok && err_r == pfe_pkg::STAT_OK && cnt_r >= CW'(2)) begin
          unique case (cmd.op)
            pfe_pkg::OP_ADD, pfe_pkg::OP_SUB: state_nxt = pfe_pkg::S_WB;
            pfe_pkg::OP_MUL:                  state_nxt = pfe_pkg::S_MUL;
            pfe_pkg::OP_DIV: begin
              if (tos_r != '0) begin
                state_nxt = pfe_pkg::S_DIV;
              end
            end
            default:                          state_nxt = pfe_pkg::S_IDLE;
          endcase
        end
      end
      pfe_pkg::S_MUL: if (mul_done) state_nxt = pfe_pkg::S_WB;
      pfe_pkg::S_DIV: if (div_done) state_nxt = pfe_pkg::S_WB;
      pfe_pkg::S_WB:  state_nxt = pfe_pkg::S_IDLE;
      default:        state_nxt = pfe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic             fin;
    logic [CW-1:0]    f_cnt;
    pfe_pkg::status_t f_err;
    pfe_pkg::val_t    f_tos;
    logic             f_last;

    fin            = 1'b0;
    f_cnt          = cnt_r;
    f_err          = err_r;
    f_tos          = tos_r;
    f_last         = cmd.last;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    tos_nxt        = tos_r;
    nos_nxt        = nos_r;
    res_nxt        = res_r;
    last_nxt       = last_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[AW-1:0];
    mem_wdata      = digit_val;
    mem_re         = 1'b0;
    mem_raddr      = cnt_m3[AW-1:0];
    mul_start      = 1'b0;
    div_start      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_top_nxt    = out_top_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;

    unique case (state_r)
      pfe_pkg::S_IDLE: begin
        if (start_ok) begin
          fin = 1'b1;
          if (err_r == pfe_pkg::STAT_OK) begin
            unique case (cmd.op)
              pfe_pkg::OP_DIGIT: begin
                if (cnt_r >= CW'(STACK_DEPTH)) begin
                  f_err = pfe_pkg::STAT_OVERFLOW;
                end else begin
                  mem_we  = 1'b1;
                  nos_nxt = tos_r;
                  f_tos   = digit_val;
                  f_cnt   = cnt_r + CW'(1);
                end
              end
              pfe_pkg::OP_BAD: f_err = pfe_pkg::STAT_BAD_CHAR;
              default: begin
                if (cnt_r < CW'(2)) begin
                  f_err = pfe_pkg::STAT_UNDERFLOW;
                end else if (cmd.op == pfe_pkg::OP_DIV && tos_r == '0) begin
                  f_err = pfe_pkg::STAT_DIV_ZERO;
                end else begin
                  fin       = 1'b0;
                  mem_re    = 1'b1;
                  last_nxt  = cmd.last;
                  res_nxt   = addsub_res;
                  mul_start = (cmd.op == pfe_pkg::OP_MUL);
                  div_start = (cmd.op == pfe_pkg::OP_DIV);
                end
              end
            endcase
          end
        end
      end
      pfe_pkg::S_MUL: if (mul_done) res_nxt = mul_res;
      pfe_pkg::S_DIV: if (div_done) res_nxt = div_res;
      pfe_pkg::S_WB: begin
        fin       = 1'b1;
        f_last    = last_r;
        f_tos     = res_r;
        f_cnt     = cnt_r - CW'(1);
        nos_nxt   = rd_data_r;
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[AW-1:0];
        mem_wdata = res_r;
      end
      default: ;
    endcase

    if (fin) begin
      out_valid_nxt = 1'b1;
      out_done_nxt  = f_last;
      out_top_nxt   = (f_cnt != '0) ? f_tos : '0;
      if (f_last && f_err == pfe_pkg::STAT_OK && f_cnt > CW'(1)) begin
        out_status_nxt = pfe_pkg::STAT_LEFTOVER;
      end else begin
        out_status_nxt = f_err;
      end
      tos_nxt = f_tos;
      if (f_last) begin
        cnt_nxt = '0;
        err_nxt = pfe_pkg::STAT_OK;
      end else begin
        cnt_nxt = f_cnt;
        err_nxt = f_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfe_pkg::S_IDLE;
      cnt_r       <= '0;
      err_r       <= pfe_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    nos_r        <= nos_nxt;
    res_r        <= res_nxt;
    last_r       <= last_nxt;
    out_top_r    <= out_top_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_top    = out_top_r;
  assign out_status = out_status_r;
  assign out_done   = out_done_r;

endmodule
